// ===== rtl/c_escape_sequence_decoder_top_assert.svh =====
// ----------------------------------------------------------------------------
// Escape decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during rst.
// ----------------------------------------------------------------------------
`ifndef C_ESCAPE_SEQUENCE_DECODER_TOP_ASSERT_SVH
`define C_ESCAPE_SEQUENCE_DECODER_TOP_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define CED_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that implies a consequence in the same cycle
`define CED_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition that implies a consequence in the next cycle
`define CED_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ced_pkg.sv =====
// ----------------------------------------------------------------------------
// Escape decoder package
// Character codes, result constants, queue entry type and digit decode.
// ----------------------------------------------------------------------------
`default_nettype none

package ced_pkg;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LE     = 8'h65;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LV     = 8'h76;
  localparam logic [7:0] CH_LX     = 8'h78;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  // decoded single-letter escapes
  localparam logic [7:0] BYTE_BEL = 8'h07;
  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_ESC = 8'h1B;
  localparam logic [7:0] BYTE_FF  = 8'h0C;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_TAB = 8'h09;
  localparam logic [7:0] BYTE_VT  = 8'h0B;

  // digit limits of numeric escapes
  localparam logic [1:0] OCT_DIGITS = 2'd3;
  localparam logic [1:0] HEX_DIGITS = 2'd2;

  // width of the shown length field
  localparam int unsigned SHOWN_BITS = 16;

  // one queue entry: the one or two results caused by one item
  typedef struct packed {
    logic [7:0] b0;
    logic       t0;
    logic       has1;
    logic [7:0] b1;
    logic       t1;
  } ced_entry_t;

  // digit decode: bit 4 is valid, bits 3:0 the value
  function automatic logic [4:0] digit_value(input logic [7:0] b);
    logic [7:0] off;
    logic [4:0] res;
    off = 8'h00;
    res = 5'h00;
    if (b >= CH_0 && b <= CH_9) begin
      off = b - CH_0;
      res = {1'b1, off[3:0]};
    end else if (b >= CH_LA && b <= CH_LF) begin
      off = b - CH_LA + 8'd10;
      res = {1'b1, off[3:0]};
    end else if (b >= CH_UA && b <= CH_UF) begin
      off = b - CH_UA + 8'd10;
      res = {1'b1, off[3:0]};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ced_front.sv =====
// ----------------------------------------------------------------------------
// Escape decoder front end
// Accepts raw bytes, tracks escape and number state, and pushes the results
// each item causes as one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ced_front import ced_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_mark,
  input  logic       q_full,
  output logic       push,
  output ced_entry_t entry
);

  typedef enum logic [1:0] {
    PH_TEXT   = 2'd0,
    PH_ESCAPE = 2'd1,
    PH_NUMBER = 2'd2
  } phase_t;

  phase_t     phase, phase_next;
  logic       hex_base, hex_base_next;
  logic [1:0] digits, digits_next;
  logic [7:0] acc, acc_next;

  logic       accept;
  logic       emit0;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && emit0;

  // decode of one item
  always_comb begin
    logic       is_end;
    logic       as_text;
    logic [4:0] dv;
    logic       dig_ok;
    logic [7:0] acc_dig;
    logic [1:0] dig_inc;
    is_end        = end_mark || (in_byte == CH_NUL);
    as_text       = 1'b1;
    dv            = digit_value(in_byte);
    dig_ok        = !is_end && dv[4] && (hex_base || !dv[3]);
    acc_dig       = hex_base ? {acc[3:0], dv[3:0]} : {acc[4:0], dv[2:0]};
    dig_inc       = digits + 2'd1;
    phase_next    = phase;
    hex_base_next = hex_base;
    digits_next   = digits;
    acc_next      = acc;
    emit0         = 1'b0;
    entry         = '0;

    unique case (phase)
      PH_NUMBER: begin
        if (dig_ok) begin
          as_text     = 1'b0;
          acc_next    = acc_dig;
          digits_next = dig_inc;
          if (dig_inc >= (hex_base ? HEX_DIGITS : OCT_DIGITS)) begin
            emit0      = 1'b1;
            entry.b0   = acc_dig;
            phase_next = PH_TEXT;
          end
        end else begin
          // pending number goes out before the byte is handled as text
          emit0      = 1'b1;
          entry.b0   = acc;
          phase_next = PH_TEXT;
        end
      end
      PH_ESCAPE: begin
        phase_next = PH_TEXT;
        if (!is_end) begin
          as_text = 1'b0;
          case (in_byte)
            CH_LA: begin emit0 = 1'b1; entry.b0 = BYTE_BEL; end
            CH_LB: begin emit0 = 1'b1; entry.b0 = BYTE_BS;  end
            CH_LE: begin emit0 = 1'b1; entry.b0 = BYTE_ESC; end
            CH_LF: begin emit0 = 1'b1; entry.b0 = BYTE_FF;  end
            CH_LN: begin emit0 = 1'b1; entry.b0 = BYTE_LF;  end
            CH_LR: begin emit0 = 1'b1; entry.b0 = BYTE_CR;  end
            CH_LT: begin emit0 = 1'b1; entry.b0 = BYTE_TAB; end
            CH_LV: begin emit0 = 1'b1; entry.b0 = BYTE_VT;  end
            CH_LX: begin
              phase_next    = PH_NUMBER;
              hex_base_next = 1'b1;
              acc_next      = 8'h00;
              digits_next   = 2'd0;
            end
            default: begin
              if (in_byte >= CH_0 && in_byte <= CH_7) begin
                phase_next    = PH_NUMBER;
                hex_base_next = 1'b0;
                acc_next      = {5'b0, dv[2:0]};
                digits_next   = 2'd1;
              end else begin
                emit0    = 1'b1;
                entry.b0 = in_byte;
              end
            end
          endcase
        end
      end
      default: ;
    endcase

    // plain text handling, possibly as the second result
    if (as_text) begin
      if (is_end) begin
        if (emit0) begin
          entry.has1 = 1'b1;
          entry.t1   = 1'b1;
        end else begin
          emit0    = 1'b1;
          entry.t0 = 1'b1;
        end
        phase_next    = PH_TEXT;
        hex_base_next = 1'b0;
        digits_next   = 2'd0;
        acc_next      = 8'h00;
      end else if (in_byte == CH_BSLASH) begin
        phase_next = PH_ESCAPE;
      end else if (emit0) begin
        entry.has1 = 1'b1;
        entry.b1   = in_byte;
      end else begin
        emit0    = 1'b1;
        entry.b0 = in_byte;
      end
    end
  end

  // decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_TEXT;
      hex_base <= 1'b0;
      digits   <= 2'd0;
      acc      <= 8'h00;
    end else if (accept) begin
      phase    <= phase_next;
      hex_base <= hex_base_next;
      digits   <= digits_next;
      acc      <= acc_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ced_queue.sv =====
// ----------------------------------------------------------------------------
// Escape decoder result queue
// Small register queue of result entries between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ced_queue import ced_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  ced_entry_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output ced_entry_t head
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ced_entry_t    mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ced_back.sv =====
// ----------------------------------------------------------------------------
// Escape decoder back end
// Drains queue entries one result at a time, counts decoded bytes and holds
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "c_escape_sequence_decoder_top_assert.svh"

module ced_back import ced_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  ced_entry_t  q_head,
  output logic        q_pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  output logic        m_tuser,
  output logic        m_tlast
);

  localparam int unsigned WW = LENGTH_BITS + SHOWN_BITS;

  logic                   slot;
  logic [LENGTH_BITS-1:0] cnt;
  logic                   load;
  logic [7:0]             cur_byte;
  logic                   cur_term;
  logic                   cur_last;
  logic [LENGTH_BITS-1:0] cnt_inc;
  logic [LENGTH_BITS-1:0] cnt_new;
  logic [WW-1:0]          cnt_wide;
  logic [SHOWN_BITS-1:0]  shown;

  // pick the current result of the head entry
  assign cur_byte = slot ? q_head.b1 : q_head.b0;
  assign cur_term = slot ? q_head.t1 : q_head.t0;
  assign cur_last = slot || !q_head.has1;
  assign load     = q_valid && (!m_tvalid || m_tready);
  assign q_pop    = load && cur_last;

  // saturating length, shown clipped to the field width
  assign cnt_inc  = (cnt == '1) ? cnt : cnt + 1'b1;
  assign cnt_new  = cur_term ? cnt : cnt_inc;
  assign cnt_wide = WW'(cnt_new);
  assign shown    = (cnt_wide > WW'({SHOWN_BITS{1'b1}})) ? '1 : cnt_wide[SHOWN_BITS-1:0];

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot     <= 1'b0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        slot     <= !cur_last;
        cnt      <= cur_term ? '0 : cnt_new;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {shown, cur_term ? 8'h00 : cur_byte};
      m_tuser <= cur_term;
      m_tlast <= cur_last;
    end
  end

  `CED_ASSERT_IMPL(a_term, m_tvalid && m_tuser, m_tlast && ~|m_tdata[7:0], "bad terminator item")
  `CED_ASSERT_NEXT(a_term_clears, load && cur_term, cnt == '0, "length kept after terminator")
  `CED_ASSERT_IMPL(a_second_slot, slot, q_valid && q_head.has1, "second slot without entry")

endmodule

`default_nettype wire

// ===== rtl/c_escape_sequence_decoder_top.sv =====
// Escape string decoder. Raw string bytes enter on the s_ side, one item per
// cycle while s_tready is high; s_tlast marks the end of a string (a zero
// byte ends it too). Decoded bytes leave on the m_ side; each string closes
// with a terminator item (m_tuser high) carrying the decoded length, and
// m_tlast marks the last result caused by one input item. The front end
// writes the results of each accepted item, if any, as one entry of a
// QUEUE_DEPTH entry queue; the back end drains one result per cycle, while
// m_tready allows, from the queue into the output register. With m_tready
// high the rate is one item per cycle, but an item with two results needs an
// output transfer for each. s_tready drops only while the queue is full.
// ----------------------------------------------------------------------------
// Escape string decoder top level
// Front end decode, result queue and back end output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module c_escape_sequence_decoder_top import ced_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 16,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // end_mark
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] decoded_length
  output logic        m_tuser,   // is_terminator
  output logic        m_tlast    // run_last
);

  logic       q_full;
  logic       push;
  ced_entry_t push_data;
  logic       q_valid;
  ced_entry_t q_head;
  logic       q_pop;

  // decode front end
  ced_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .end_mark (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .entry    (push_data)
  );

  // result queue
  ced_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // output back end
  ced_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Escape string decoder testbench
// Drives raw string bytes into the decoder and checks every decoded byte and
// terminator against an in-bench decoder model. Covers directed escapes,
// long strings, output backpressure, drain pauses and random strings.
// ----------------------------------------------------------------------------

module tb_top;
  import ced_pkg::*;

  // decode state of the in-bench model
  typedef enum logic [1:0] {ST_TEXT, ST_AFTER_BSLASH, ST_DIGITS} dec_state_t;

  // receiver behavior
  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  // one decoded result as it should leave the block
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_term;
    logic [15:0] length;
    logic        last;
  } decoded_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] in_byte
  logic        s_tlast = 1'b0;    // end_mark
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;           // [7:0] out_byte, [23:8] decoded_length
  logic        m_tuser;           // is_terminator
  logic        m_tlast;           // run_last

  // model state
  dec_state_t  dec_state = ST_TEXT;
  logic        hex_mode = 1'b0;
  logic [1:0]  digit_count = 2'd0;
  logic [7:0]  number_val = 8'h00;
  logic [15:0] string_len = 16'd0;

  decoded_t    decoded_q[$];
  int          mismatches = 0;
  int          items_sent = 0;

  // stimulus pacing
  bit          sender_gaps = 1'b0;
  int          burst_left = 0;
  rx_mode_t    rx_mode = RX_ALWAYS;
  logic [15:0] rx_pattern = 16'hA5C3;
  logic [15:0] pattern_seed = 16'h0000;
  int          hold_request = 0;
  int          hold_left = 0;

  logic [7:0]  escape_letters[8] = '{CH_LA, CH_LB, CH_LE, CH_LF, CH_LN, CH_LR, CH_LT, CH_LV};

  c_escape_sequence_decoder_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // decoder model
  // ------------------------------------------------------------------------

  // value of a hex or decimal digit character, -1 if none
  function automatic int char_to_num(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    return -1;
  endfunction

  // one decoded byte, counted into the string length
  function automatic decoded_t data_result(input logic [7:0] v);
    decoded_t r;
    if (string_len != 16'hFFFF) string_len++;
    r.out_byte = v;
    r.is_term = 1'b0;
    r.length = string_len;
    r.last = 1'b0;
    return r;
  endfunction

  // model one accepted item and queue the results it causes
  task automatic decode_item(input logic [7:0] b, input logic end_mark);
    decoded_t res[2];
    int       n;
    int       d;
    int       base;
    int       digit_limit;
    logic     flush;
    logic     as_text;
    flush = end_mark || (b == CH_NUL);
    as_text = 1'b1;
    n = 0;
    case (dec_state)
      ST_DIGITS: begin
        base = hex_mode ? 16 : 8;
        digit_limit = hex_mode ? HEX_DIGITS : OCT_DIGITS;
        d = flush ? -1 : char_to_num(b);
        if (d >= 0 && d < base) begin
          number_val = 8'(int'(number_val) * base + d);
          digit_count = digit_count + 2'd1;
          as_text = 1'b0;
          // number full: emit now
          if (digit_count >= digit_limit) begin
            res[n] = data_result(number_val);
            n++;
            dec_state = ST_TEXT;
          end
        end else begin
          // cut short: emit the number, then treat this byte as text
          res[n] = data_result(number_val);
          n++;
          dec_state = ST_TEXT;
        end
      end
      ST_AFTER_BSLASH: begin
        dec_state = ST_TEXT;
        if (!flush) begin
          as_text = 1'b0;
          case (b)
            CH_LA: begin res[n] = data_result(BYTE_BEL); n++; end
            CH_LB: begin res[n] = data_result(BYTE_BS); n++; end
            CH_LE: begin res[n] = data_result(BYTE_ESC); n++; end
            CH_LF: begin res[n] = data_result(BYTE_FF); n++; end
            CH_LN: begin res[n] = data_result(BYTE_LF); n++; end
            CH_LR: begin res[n] = data_result(BYTE_CR); n++; end
            CH_LT: begin res[n] = data_result(BYTE_TAB); n++; end
            CH_LV: begin res[n] = data_result(BYTE_VT); n++; end
            CH_LX: begin
              dec_state = ST_DIGITS;
              hex_mode = 1'b1;
              number_val = 8'h00;
              digit_count = 2'd0;
            end
            default: begin
              if (b >= CH_0 && b <= CH_7) begin
                dec_state = ST_DIGITS;
                hex_mode = 1'b0;
                number_val = b - CH_0;
                digit_count = 2'd1;
              end else begin
                res[n] = data_result(b);
                n++;
              end
            end
          endcase
        end
      end
      default: ;
    endcase

    if (as_text) begin
      if (flush) begin
        // terminator carries the length, then a fresh string starts
        res[n] = '{out_byte: 8'h00, is_term: 1'b1, length: string_len, last: 1'b0};
        n++;
        dec_state = ST_TEXT;
        hex_mode = 1'b0;
        digit_count = 2'd0;
        number_val = 8'h00;
        string_len = 16'd0;
      end else if (b == CH_BSLASH) begin
        dec_state = ST_AFTER_BSLASH;
      end else begin
        res[n] = data_result(b);
        n++;
      end
    end

    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) decoded_q.push_back(res[i]);
  endtask

  // ------------------------------------------------------------------------
  // sender side
  // ------------------------------------------------------------------------

  // offer one item, wait for the handshake, then model it
  task automatic send_item(input logic [7:0] b, input logic end_mark);
    if (sender_gaps) begin
      if (burst_left == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= end_mark;
    do @(posedge clk); while (!s_tready);
    decode_item(b, end_mark);
    items_sent++;
  endtask

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) send_item(text[i], 1'b0);
  endtask

  // stop offering until every queued result has left the block
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  // any text byte, never a backslash or a zero
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    if (c == CH_BSLASH) c = CH_LX;
    return c;
  endfunction

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) return CH_0 + 8'(v);
    if (v < 16) return CH_LA + 8'(v - 10);
    return CH_UA + 8'(v - 16);
  endfunction

  // one random piece of a string, mostly well formed
  task automatic send_token();
    int kind;
    int cnt;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      send_item(plain_char(), 1'b0);
    end else if (kind < 45) begin
      send_item(CH_BSLASH, 1'b0);
      send_item(escape_letters[$urandom_range(0, 7)], 1'b0);
    end else if (kind < 60) begin
      cnt = $urandom_range(1, 3);
      send_item(CH_BSLASH, 1'b0);
      repeat (cnt) send_item(CH_0 + 8'($urandom_range(0, 7)), 1'b0);
    end else if (kind < 72) begin
      cnt = $urandom_range(0, 2);
      send_item(CH_BSLASH, 1'b0);
      send_item(CH_LX, 1'b0);
      repeat (cnt) send_item(hex_char(), 1'b0);
    end else if (kind < 78) begin
      send_item(CH_BSLASH, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 7) == 0));
    end else if (kind < 86) begin
      if ($urandom_range(0, 1) == 0) send_item(8'($urandom_range(0, 255)), 1'b1);
      else send_item(CH_NUL, 1'b0);
    end else begin
      send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 7) == 0));
    end
  endtask

  // ------------------------------------------------------------------------
  // receiver side
  // ------------------------------------------------------------------------

  // ready follows the chosen mode, a long hold overrides it
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (pattern_seed != 16'h0000) begin
      rx_pattern <= pattern_seed;
      pattern_seed = 16'h0000;
    end else begin
      rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_RANDOM:  m_tready <= ($urandom_range(0, 99) >= 35);
        RX_PATTERN: m_tready <= rx_pattern[0];
        default:    m_tready <= 1'b1;
      endcase
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
  endtask

  // compare each accepted result with the oldest queued one
  always @(posedge clk) begin : check_results
    decoded_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("unexpected result", {m_tlast, m_tuser, m_tdata}, 32'h0);
      end else begin
        want = decoded_q.pop_front();
        if (m_tdata[7:0] !== want.out_byte)
          report_mismatch("out_byte", m_tdata[7:0], want.out_byte);
        if (m_tdata[23:8] !== want.length)
          report_mismatch("decoded_length", m_tdata[23:8], want.length);
        if (m_tuser !== want.is_term)
          report_mismatch("is_terminator", m_tuser, want.is_term);
        if (m_tlast !== want.last)
          report_mismatch("run_last", m_tlast, want.last);
      end
    end
  end

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // letters, complete and cut-short numbers, empty hex, pass-through,
  // trailing backslash, high bytes and both ways of ending a string
  task automatic test_directed();
    sender_gaps = 1'b0;
    rx_mode = RX_ALWAYS;
    send_text("A\\n\\101\\78\\xfF\\xg");
    send_item(CH_BSLASH, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(CH_BSLASH, 1'b0);
    send_item(8'h55, 1'b1);
    send_item(8'hFF, 1'b0);
    send_text("\\xA");
    send_item(CH_NUL, 1'b0);
    wait_results_drained();
  endtask

  // one long string so the length runs well past one byte
  task automatic test_long_string();
    sender_gaps = 1'b0;
    rx_mode = RX_ALWAYS;
    for (int i = 0; i < 400; i++) send_item(CH_UA + 8'($urandom_range(0, 25)), 1'b0);
    send_item(8'hAA, 1'b1);
    wait_results_drained();
  endtask

  // receiver holds off while the sender keeps offering, so input stalls
  task automatic test_output_hold();
    sender_gaps = 1'b0;
    rx_mode = RX_ALWAYS;
    hold_request = 300;
    repeat (60) send_token();
    wait_results_drained();
  endtask

  // pause with a number still pending, then finish it
  task automatic test_drain_pause();
    sender_gaps = 1'b1;
    rx_mode = RX_RANDOM;
    send_text("q\\1");
    wait_results_drained();
    send_text("23z\\x");
    wait_results_drained();
    send_text("7");
    send_item(CH_NUL, 1'b0);
    wait_results_drained();
  endtask

  // random strings under changing pacing
  task automatic test_random_strings();
    int start;
    int phase_idx;
    start = items_sent;
    phase_idx = 0;
    while (items_sent - start < 1500) begin
      if ((items_sent - start) / 300 != phase_idx) begin
        phase_idx = (items_sent - start) / 300;
        sender_gaps = (phase_idx % 2) == 1;
        rx_mode = rx_mode_t'(phase_idx % 3);
        pattern_seed = 16'($urandom) | 16'h0001;
        if (phase_idx == 3) wait_results_drained();
      end
      send_token();
    end
    wait_results_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_long_string();
    test_output_hold();
    test_drain_pause();
    test_random_strings();
    wait_results_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
